@@ src/swfr_pkg.sv @@
package swfr_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int NOW_W    = 48;
   localparam int FRAME_W  = 32;
   localparam int DUR_W    = 31;
   localparam int WINDOW_W = 32;
   localparam int FPS_W    = 24;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000000;
   localparam logic [FPS_W-1:0]    FPS_MAX      = 24'hFFFFFF;

   // 256000000 = 125000 * 2**11
   localparam int SCALE_ODD   = 125000;
   localparam int SCALE_ODD_W = 17;
   localparam int SCALE_SHIFT = 11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVICT_RD,
      ST_EVICT,
      ST_APPEND,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

endpackage

@@ src/swfr_if.sv @@
interface swfr_req_if;
   logic                              valid;
   logic                              ready;
   logic [swfr_pkg::NOW_W-1:0]        now_us;
   logic signed [swfr_pkg::FRAME_W-1:0] frame_us;

   modport source (output valid, output now_us, output frame_us, input ready);
   modport sink   (input valid, input now_us, input frame_us, output ready);
endinterface

interface swfr_rsp_if #(
   parameter int CNT_W = 7
);
   logic                        valid;
   logic                        ready;
   logic [swfr_pkg::FPS_W-1:0]  avg_fps_q8;
   logic [CNT_W-1:0]            frames_in_window;
   logic                        overflow;

   modport source (output valid, output avg_fps_q8, output frames_in_window,
                   output overflow, input ready);
   modport sink   (input valid, input avg_fps_q8, input frames_in_window,
                   input overflow, output ready);
endinterface

interface swfr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [swfr_pkg::WINDOW_W-1:0]  window_us;

   modport source (output valid, output window_us, input ready);
   modport sink   (input valid, input window_us, output ready);
endinterface

@@ src/swfr_store.sv @@
module swfr_store #(
   parameter int DEPTH = swfr_pkg::DEPTH_DEFAULT,
   localparam int IdxW = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IdxW-1:0]             wr_addr,
   input  logic [swfr_pkg::NOW_W-1:0]  wr_end,
   input  logic [swfr_pkg::DUR_W-1:0]  wr_dur,
   input  logic [IdxW-1:0]             rd_addr,
   output logic [swfr_pkg::NOW_W-1:0]  rd_end,
   output logic [swfr_pkg::DUR_W-1:0]  rd_dur
);

   logic [swfr_pkg::NOW_W-1:0] end_mem [DEPTH];
   logic [swfr_pkg::DUR_W-1:0] dur_mem [DEPTH];
   logic [swfr_pkg::NOW_W-1:0] rd_end_ff;
   logic [swfr_pkg::DUR_W-1:0] rd_dur_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         end_mem[wr_addr] <= wr_end;
         dur_mem[wr_addr] <= wr_dur;
      end
   end

   always_ff @(posedge clock) begin
      rd_end_ff <= end_mem[rd_addr];
      rd_dur_ff <= dur_mem[rd_addr];
   end

   assign rd_end = rd_end_ff;
   assign rd_dur = rd_dur_ff;

endmodule

@@ src/swfr_div.sv @@
module swfr_div #(
   parameter int CntW = 7,
   parameter int SumW = 38
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [CntW-1:0]             count,
   input  logic [SumW-1:0]             sum,
   output logic                        done,
   output logic [swfr_pkg::FPS_W-1:0]  fps
);

   localparam int ProdW = CntW + swfr_pkg::SCALE_ODD_W;
   localparam int NumW  = ProdW + swfr_pkg::SCALE_SHIFT;
   localparam int StepW = $clog2(NumW);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             zero_ff, zero_in;
   logic [NumW-1:0]  num_ff, num_in;
   logic [SumW-1:0]  den_ff, den_in;
   logic [SumW-1:0]  rem_ff, rem_in;
   logic [NumW-1:0]  quo_ff, quo_in;

   logic [ProdW-1:0] prod;
   logic [SumW:0]    shifted;
   logic [SumW:0]    diff;
   logic             fits;

   assign prod    = ProdW'(count) * ProdW'(swfr_pkg::SCALE_ODD);
   assign shifted = {rem_ff, num_ff[NumW-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      zero_in = zero_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = StepW'(NumW - 1);
         zero_in = (sum == '0);
         num_in  = {prod, {swfr_pkg::SCALE_SHIFT{1'b0}}};
         den_in  = sum;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         quo_in = {quo_ff[NumW-2:0], fits};
         rem_in = fits ? diff[SumW-1:0] : shifted[SumW-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      zero_ff <= zero_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;

   always_comb begin
      if (zero_ff) begin
         fps = '0;
      end else if (|quo_ff[NumW-1:swfr_pkg::FPS_W]) begin
         fps = swfr_pkg::FPS_MAX;
      end else begin
         fps = quo_ff[swfr_pkg::FPS_W-1:0];
      end
   end

endmodule

@@ src/sliding_window_frame_rate.sv @@
// Sliding-window frame-rate meter.
// req_bus carries one frame per transaction: now_us (end time) and frame_us
// (duration). A positive duration is appended to a DEPTH-entry FIFO with a
// running duration sum; a full FIFO evicts its oldest frame first and flags
// overflow. Frames whose end time plus window_us lies before now_us are then
// dropped from the front. rsp_bus returns one transaction per frame:
// avg_fps_q8 = count * 256e6 / sum (Q16.8, saturated, 0 on empty sum),
// frames_in_window and overflow.
// csr_bus writes window_us; write it only while the block is idle.
// After acceptance, a frame with a non-positive duration goes straight to the
// expiry walk, an append passes through ST_APPEND and an append that evicts
// through ST_EVICT_RD and ST_EVICT. The expiry walk reads each frame through
// the store's registered read port in ST_WALK_RD and checks it in ST_WALK_CHK,
// and skips the check when the FIFO is empty; then the divider forms the
// quotient bit by bit. One frame is in work at a time: the next frame is
// taken only after the result is posted.
// Reset empties the FIFO, zeroes the sum and sets window_us to 1000000.
// When the receiver stalls, a finished result waits in the output register
// and the next result, with the input, is held until the register is free.
module sliding_window_frame_rate #(
   parameter int DEPTH = swfr_pkg::DEPTH_DEFAULT,
   localparam int IdxW = $clog2(DEPTH),
   localparam int CntW = $clog2(DEPTH + 1)
) (
   input  logic        clock,
   input  logic        reset,
   swfr_req_if.sink    req_bus,
   swfr_rsp_if.source  rsp_bus,
   swfr_csr_if.sink    csr_bus
);

   localparam int SumW = swfr_pkg::DUR_W + CntW;

   swfr_pkg::state_type state_ff, state_in;

   logic [swfr_pkg::WINDOW_W-1:0] window_ff;
   logic [IdxW-1:0]               oldest_ff, oldest_in;
   logic [CntW-1:0]               count_ff, count_in;
   logic [SumW-1:0]               sum_ff, sum_in;
   logic [swfr_pkg::NOW_W-1:0]    now_ff, now_in;
   logic [swfr_pkg::DUR_W-1:0]    dur_ff, dur_in;
   logic                          ovf_ff, ovf_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swfr_pkg::FPS_W-1:0]    rsp_fps_ff, rsp_fps_in;
   logic [CntW-1:0]               rsp_cnt_ff, rsp_cnt_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic                          wr_en;
   logic [IdxW-1:0]               wr_addr;
   logic [swfr_pkg::NOW_W-1:0]    rd_end;
   logic [swfr_pkg::DUR_W-1:0]    rd_dur;
   logic                          div_start;
   logic                          div_done;
   logic [swfr_pkg::FPS_W-1:0]    div_fps;

   logic                          req_pos;
   logic                          full;
   logic [IdxW-1:0]               oldest_next;
   logic [IdxW:0]                 slot_sum;
   logic [IdxW-1:0]               append_slot;
   logic                          expired;

   assign req_pos = !req_bus.frame_us[swfr_pkg::FRAME_W-1] && (req_bus.frame_us != '0);
   assign full    = (count_ff == CntW'(DEPTH));
   assign oldest_next = (oldest_ff == IdxW'(DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   assign slot_sum = (IdxW+1)'(oldest_ff) + (IdxW+1)'(count_ff);
   assign append_slot = (slot_sum >= (IdxW+1)'(DEPTH)) ?
                        IdxW'(slot_sum - (IdxW+1)'(DEPTH)) : slot_sum[IdxW-1:0];
   assign expired = ({1'b0, rd_end} + (swfr_pkg::NOW_W+1)'(window_ff))
                    < {1'b0, now_ff};

   swfr_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_end  (now_ff),
      .wr_dur  (dur_ff),
      .rd_addr (oldest_ff),
      .rd_end  (rd_end),
      .rd_dur  (rd_dur)
   );

   swfr_div #(
      .CntW (CntW),
      .SumW (SumW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .count (count_ff),
      .sum   (sum_ff),
      .done  (div_done),
      .fps   (div_fps)
   );

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      now_in       = now_ff;
      dur_in       = dur_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = append_slot;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_fps_in   = rsp_fps_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         swfr_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               now_in = req_bus.now_us;
               dur_in = req_bus.frame_us[swfr_pkg::DUR_W-1:0];
               ovf_in = 1'b0;
               if (!req_pos) begin
                  state_in = swfr_pkg::ST_WALK_RD;
               end else if (full) begin
                  state_in = swfr_pkg::ST_EVICT_RD;
               end else begin
                  state_in = swfr_pkg::ST_APPEND;
               end
            end
         end
         swfr_pkg::ST_EVICT_RD: begin
            state_in = swfr_pkg::ST_EVICT;
         end
         swfr_pkg::ST_EVICT: begin
            wr_en     = 1'b1;
            wr_addr   = oldest_ff;
            sum_in    = sum_ff - SumW'(rd_dur) + SumW'(dur_ff);
            oldest_in = oldest_next;
            ovf_in    = 1'b1;
            state_in  = swfr_pkg::ST_WALK_RD;
         end
         swfr_pkg::ST_APPEND: begin
            wr_en    = 1'b1;
            sum_in   = sum_ff + SumW'(dur_ff);
            count_in = count_ff + 1'b1;
            state_in = swfr_pkg::ST_WALK_RD;
         end
         swfr_pkg::ST_WALK_RD: begin
            state_in = (count_ff == '0) ? swfr_pkg::ST_DIV_START : swfr_pkg::ST_WALK_CHK;
         end
         swfr_pkg::ST_WALK_CHK: begin
            if (expired) begin
               sum_in    = sum_ff - SumW'(rd_dur);
               oldest_in = oldest_next;
               count_in  = count_ff - 1'b1;
               state_in  = swfr_pkg::ST_WALK_RD;
            end else begin
               state_in = swfr_pkg::ST_DIV_START;
            end
         end
         swfr_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = swfr_pkg::ST_DIV_WAIT;
         end
         swfr_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = swfr_pkg::ST_DONE;
            end
         end
         swfr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fps_in   = div_fps;
               rsp_cnt_in   = count_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = swfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swfr_pkg::ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= swfr_pkg::WINDOW_RESET;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            window_ff <= csr_bus.window_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      dur_ff     <= dur_in;
      ovf_ff     <= ovf_in;
      rsp_fps_ff <= rsp_fps_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_bus.ready            = (state_ff == swfr_pkg::ST_IDLE);
   assign csr_bus.ready            = 1'b1;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.avg_fps_q8       = rsp_fps_ff;
   assign rsp_bus.frames_in_window = rsp_cnt_ff;
   assign rsp_bus.overflow         = rsp_ovf_ff;

endmodule
